// File: rtl/pae_pkg.sv
// Package for the positional array engine.
// Holds opcodes, status codes, cell modes, sequencer states and default depth.
// No dependencies.
package pae_pkg;

   localparam int DEPTH_DEF = 256;
   localparam int GROUP_SIZE = 16;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_POS   = 3'd5,
      OP_SEARCH    = 3'd6
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CM_HOLD   = 2'd0,
      CM_INSERT = 2'd1,
      CM_DELETE = 2'd2,
      CM_SEARCH = 2'd3
   } cell_mode_type;

   typedef enum logic [2:0] {
      SQ_IDLE   = 3'd0,
      SQ_EXEC   = 3'd1,
      SQ_REDUCE = 3'd2,
      SQ_FOUND  = 3'd3,
      SQ_RESP   = 3'd4
   } seq_state_type;

endpackage

// File: rtl/positional_array_engine_unit.sv
// Top level of the positional array engine: sequencer, cell chain, match tree.
// Depends on pae_pkg, pae_cell and pae_ctrl.
//
//  channel  handshake             payload
//  req      req_valid/req_stall   req_opcode, req_position, req_value
//  rsp      rsp_valid/rsp_stall   rsp_status, rsp_found, rsp_entry_count
//
// Insert, delete and ignored ops: the request is taken in SQ_IDLE, the cells act in SQ_EXEC,
// the response is offered in SQ_RESP, then SQ_IDLE takes the next request; a search adds SQ_REDUCE and SQ_FOUND,
// set by the registered match bits and the registered first OR tree level.
// One item is in flight at a time; req_stall is high until the response moves.
// Synchronous reset empties the store; entries are never cleared.
// A stalled response holds until rsp_stall drops.
module positional_array_engine_unit #(
   parameter int DEPTH = pae_pkg::DEPTH_DEF,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_opcode,
   input  logic [CNT_W-1:0]    req_position,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic                rsp_found,
   output logic [CNT_W-1:0]    rsp_entry_count
);

   localparam int GRP = pae_pkg::GROUP_SIZE;
   localparam int NGRP = (DEPTH + GRP - 1) / GRP;

   pae_pkg::cell_mode_type cell_mode;
   logic [CNT_W-1:0]       cell_at;
   logic [CNT_W-1:0]       cell_count;
   logic signed [31:0]     cell_key;
   logic                   match_any;

   logic signed [31:0] entry_w [DEPTH];
   logic               match_w [DEPTH];
   logic               group_ff [NGRP];
   logic               group_in [NGRP];

   pae_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_entry_count(rsp_entry_count),
      .cell_mode      (cell_mode),
      .cell_at        (cell_at),
      .cell_count     (cell_count),
      .cell_key       (cell_key),
      .match_any      (match_any)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] left_w;
      logic signed [31:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid
         assign left_w = entry_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_inner
         assign right_w = entry_w[i+1];
      end
      pae_cell #(
         .DEPTH(DEPTH),
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .mode       (cell_mode),
         .at         (cell_at),
         .count      (cell_count),
         .key        (cell_key),
         .left_entry (left_w),
         .right_entry(right_w),
         .entry      (entry_w[i]),
         .match      (match_w[i])
      );
   end

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         group_in[g] = 1'b0;
         for (int k = 0; k < GRP; k++) begin
            if (g * GRP + k < DEPTH) begin
               group_in[g] = group_in[g] | match_w[g * GRP + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NGRP; g++) begin
         group_ff[g] <= group_in[g];
      end
   end

   always_comb begin
      match_any = 1'b0;
      for (int g = 0; g < NGRP; g++) begin
         match_any = match_any | group_ff[g];
      end
   end

endmodule

// File: rtl/pae_cell.sv
// One storage cell of the positional array chain.
// Holds one entry and trades it with its neighbors; flags a search match.
// Depends on pae_pkg.
module pae_cell #(
   parameter int DEPTH = pae_pkg::DEPTH_DEF,
   parameter int INDEX = 0,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pae_pkg::cell_mode_type mode,
   input  logic [CNT_W-1:0]      at,
   input  logic [CNT_W-1:0]      count,
   input  logic signed [31:0]    key,
   input  logic signed [31:0]    left_entry,
   input  logic signed [31:0]    right_entry,
   output logic signed [31:0]    entry,
   output logic                  match
);

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic signed [31:0] entry_ff, entry_in;
   logic               match_ff, match_in;

   always_comb begin
      entry_in = entry_ff;
      match_in = match_ff;
      case (mode)
         pae_pkg::CM_INSERT: begin
            if (IDX > at) begin
               entry_in = left_entry;
            end else if (IDX == at) begin
               entry_in = key;
            end
         end
         pae_pkg::CM_DELETE: begin
            if (IDX >= at) begin
               entry_in = right_entry;
            end
         end
         pae_pkg::CM_SEARCH: begin
            match_in = (entry_ff == key) && (IDX < count);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// File: rtl/pae_ctrl.sv
// Sequencer of the positional array engine.
// Takes requests, decodes status, drives the cell chain, returns responses.
// Depends on pae_pkg.
module pae_ctrl #(
   parameter int DEPTH = pae_pkg::DEPTH_DEF,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_opcode,
   input  logic [CNT_W-1:0]       req_position,
   input  logic signed [31:0]     req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic                   rsp_found,
   output logic [CNT_W-1:0]       rsp_entry_count,
   output pae_pkg::cell_mode_type cell_mode,
   output logic [CNT_W-1:0]       cell_at,
   output logic [CNT_W-1:0]       cell_count,
   output logic signed [31:0]     cell_key,
   input  logic                   match_any
);

   pae_pkg::seq_state_type state_ff, state_in;
   logic [2:0]             op_ff, op_in;
   logic [CNT_W-1:0]       pos_ff, pos_in;
   logic signed [31:0]     key_ff, key_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   pae_pkg::status_type    status_ff, status_in;
   logic                   found_ff, found_in;

   pae_pkg::status_type    exec_status;
   pae_pkg::cell_mode_type exec_mode;
   logic [CNT_W-1:0]       exec_at;
   logic                   exec_ins;
   logic                   exec_del;

   always_comb begin
      exec_ins = 1'b0;
      exec_del = 1'b0;
      exec_at  = '0;
      case (pae_pkg::opcode_type'(op_ff))
         pae_pkg::OP_INS_FRONT: begin
            exec_ins = 1'b1;
         end
         pae_pkg::OP_INS_BACK: begin
            exec_ins = 1'b1;
            exec_at  = count_ff;
         end
         pae_pkg::OP_INS_POS: begin
            exec_ins = 1'b1;
            exec_at  = pos_ff;
         end
         pae_pkg::OP_DEL_FRONT: begin
            exec_del = 1'b1;
         end
         pae_pkg::OP_DEL_BACK: begin
            exec_del = 1'b1;
            exec_at  = count_ff - CNT_W'(1);
         end
         pae_pkg::OP_DEL_POS: begin
            exec_del = 1'b1;
            exec_at  = pos_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      exec_status = pae_pkg::ST_OK;
      exec_mode   = pae_pkg::CM_HOLD;
      if (exec_ins) begin
         if (exec_at > count_ff) begin
            exec_status = pae_pkg::ST_BADPOS;
         end else if (count_ff >= CNT_W'(DEPTH)) begin
            exec_status = pae_pkg::ST_FULL;
         end else begin
            exec_mode = pae_pkg::CM_INSERT;
         end
      end else if (exec_del) begin
         if (count_ff == '0) begin
            exec_status = pae_pkg::ST_EMPTY;
         end else if (exec_at >= count_ff) begin
            exec_status = pae_pkg::ST_BADPOS;
         end else begin
            exec_mode = pae_pkg::CM_DELETE;
         end
      end else if (op_ff == pae_pkg::OP_SEARCH) begin
         exec_mode = pae_pkg::CM_SEARCH;
         if (count_ff == '0) begin
            exec_status = pae_pkg::ST_EMPTY;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pae_pkg::SQ_IDLE: begin
            if (req_valid) begin
               state_in = pae_pkg::SQ_EXEC;
            end
         end
         pae_pkg::SQ_EXEC: begin
            if (op_ff == pae_pkg::OP_SEARCH) begin
               state_in = pae_pkg::SQ_REDUCE;
            end else begin
               state_in = pae_pkg::SQ_RESP;
            end
         end
         pae_pkg::SQ_REDUCE: begin
            state_in = pae_pkg::SQ_FOUND;
         end
         pae_pkg::SQ_FOUND: begin
            state_in = pae_pkg::SQ_RESP;
         end
         pae_pkg::SQ_RESP: begin
            if (!rsp_stall) begin
               state_in = pae_pkg::SQ_IDLE;
            end
         end
         default: begin
            state_in = pae_pkg::SQ_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cell_mode = pae_pkg::CM_HOLD;
      case (state_ff)
         pae_pkg::SQ_IDLE: begin
            req_stall = 1'b0;
         end
         pae_pkg::SQ_EXEC: begin
            cell_mode = exec_mode;
         end
         pae_pkg::SQ_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      op_in     = op_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      status_in = status_ff;
      found_in  = found_ff;
      if (state_ff == pae_pkg::SQ_IDLE && req_valid) begin
         op_in  = req_opcode;
         pos_in = req_position;
         key_in = req_value;
      end
      if (state_ff == pae_pkg::SQ_EXEC) begin
         status_in = exec_status;
         found_in  = 1'b0;
         if (exec_mode == pae_pkg::CM_INSERT) begin
            count_in = count_ff + CNT_W'(1);
         end else if (exec_mode == pae_pkg::CM_DELETE) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
      if (state_ff == pae_pkg::SQ_FOUND) begin
         found_in = match_any;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pae_pkg::SQ_IDLE;
         count_ff  <= '0;
         status_ff <= pae_pkg::ST_OK;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      pos_ff <= pos_in;
      key_ff <= key_in;
   end

   assign cell_at         = exec_at;
   assign cell_count      = count_ff;
   assign cell_key        = key_ff;
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_entry_count = count_ff;

endmodule

// File: sim/positional_array_engine_unit_tb.sv
// Testbench for positional_array_engine_unit: drives insert, delete and search transfers
// and checks every response against an in-bench shadow of the array and its count.
// Depends on pae_pkg and the RTL of positional_array_engine_unit only.
`timescale 1ns / 1ps

module positional_array_engine_unit_tb;

   localparam int DEPTH = pae_pkg::DEPTH_DEF;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam logic [CNT_W-1:0] POS_MAX = '1;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 500000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      pae_pkg::status_type status;
      logic                found;
      logic [CNT_W-1:0]    entry_count;
   } array_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_opcode = '0;
   logic [CNT_W-1:0] req_position = '0;
   logic signed [31:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic rsp_found;
   logic [CNT_W-1:0] rsp_entry_count;

   logic signed [31:0] shadow_entries [DEPTH];
   int shadow_count = 0;
   array_reply_type pending_replies [$];

   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic hold_kick = 1'b0;
   int hold_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   positional_array_engine_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- shadow array

   function automatic pae_pkg::status_type shift_in(int at, logic signed [31:0] val);
      if (at > shadow_count) return pae_pkg::ST_BADPOS;
      if (shadow_count >= DEPTH) return pae_pkg::ST_FULL;
      for (int i = shadow_count; i > at; i--) shadow_entries[i] = shadow_entries[i - 1];
      shadow_entries[at] = val;
      shadow_count++;
      return pae_pkg::ST_OK;
   endfunction

   function automatic pae_pkg::status_type shift_out(int at);
      if (shadow_count == 0) return pae_pkg::ST_EMPTY;
      if (at >= shadow_count) return pae_pkg::ST_BADPOS;
      for (int i = at; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
      shadow_count--;
      return pae_pkg::ST_OK;
   endfunction

   function automatic array_reply_type apply_array_op(logic [2:0] op, logic [CNT_W-1:0] pos,
                                                      logic signed [31:0] val);
      array_reply_type r;
      r.status = pae_pkg::ST_OK;
      r.found = 1'b0;
      case (op)
         pae_pkg::OP_INS_FRONT: r.status = shift_in(0, val);
         pae_pkg::OP_INS_BACK:  r.status = shift_in(shadow_count, val);
         pae_pkg::OP_INS_POS:   r.status = shift_in(int'(pos), val);
         pae_pkg::OP_DEL_FRONT: r.status = shift_out(0);
         pae_pkg::OP_DEL_BACK:
            r.status = (shadow_count == 0) ? pae_pkg::ST_EMPTY : shift_out(shadow_count - 1);
         pae_pkg::OP_DEL_POS:   r.status = shift_out(int'(pos));
         pae_pkg::OP_SEARCH: begin
            if (shadow_count == 0) begin
               r.status = pae_pkg::ST_EMPTY;
            end else begin
               for (int i = 0; i < shadow_count; i++)
                  if (shadow_entries[i] == val) r.found = 1'b1;
            end
         end
         default: ;
      endcase
      r.entry_count = shadow_count[CNT_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- item choice

   function automatic logic [31:0] choose_value();
      int r;
      r = $urandom_range(99);
      if (r < 8) return 32'h8000_0000;
      if (r < 16) return 32'h7FFF_FFFF;
      if (r < 22) return 32'h0000_0000;
      if (r < 28) return 32'hFFFF_FFFF;
      if (r < 50) return $urandom_range(15);
      return $urandom;
   endfunction

   function automatic logic [31:0] choose_probe_value();
      if (shadow_count != 0 && $urandom_range(1) == 1)
         return shadow_entries[$urandom_range(shadow_count - 1)];
      return choose_value();
   endfunction

   function automatic logic [CNT_W-1:0] choose_position();
      int r;
      r = $urandom_range(99);
      if (r < 70) return CNT_W'($urandom_range(shadow_count));
      if (r < 85) return (shadow_count + 1 > POS_MAX) ? POS_MAX : CNT_W'(shadow_count + 1);
      return CNT_W'($urandom_range(POS_MAX));
   endfunction

   function automatic logic [2:0] choose_op(int ins_pct, int search_pct);
      int r;
      r = $urandom_range(99);
      if (r < ins_pct) begin
         case ($urandom_range(2))
            0: return pae_pkg::OP_INS_FRONT;
            1: return pae_pkg::OP_INS_BACK;
            default: return pae_pkg::OP_INS_POS;
         endcase
      end
      if (r < ins_pct + search_pct) return pae_pkg::OP_SEARCH;
      if (r < ins_pct + search_pct + 2) return OP_UNUSED;
      case ($urandom_range(2))
         0: return pae_pkg::OP_DEL_FRONT;
         1: return pae_pkg::OP_DEL_BACK;
         default: return pae_pkg::OP_DEL_POS;
      endcase
   endfunction

   // ---------------------------------------------------------------- request side

   task automatic set_idling(int sender_pct, int receiver_pct);
      sender_idle_pct = sender_pct;
      rsp_stall_pct = receiver_pct;
   endtask

   task automatic send_item(logic [2:0] op, logic [CNT_W-1:0] pos, logic [31:0] val);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_position <= pos;
      req_value <= val;
      do @(posedge clock); while (req_stall);
      pending_replies.push_back(apply_array_op(op, pos, val));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   task automatic run_random_items(int n_items, int ins_pct, int search_pct);
      logic [2:0] op;
      repeat (n_items) begin
         op = choose_op(ins_pct, search_pct);
         send_item(op, choose_position(),
                   (op == pae_pkg::OP_SEARCH) ? choose_probe_value() : choose_value());
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      set_idling(0, 0);
      send_item(pae_pkg::OP_SEARCH,    '0,      32'h0000_0000);
      send_item(pae_pkg::OP_DEL_FRONT, '0,      32'h0000_0000);
      send_item(pae_pkg::OP_DEL_BACK,  '0,      32'h0000_0000);
      send_item(pae_pkg::OP_DEL_POS,   '0,      32'h0000_0000);
      send_item(pae_pkg::OP_DEL_POS,   POS_MAX, 32'hFFFF_FFFF);
      send_item(pae_pkg::OP_INS_POS,   9'd1,    32'h1234_5678);
      send_item(pae_pkg::OP_INS_POS,   '0,      32'h8000_0000);
      send_item(pae_pkg::OP_INS_BACK,  '0,      32'h7FFF_FFFF);
      send_item(pae_pkg::OP_INS_FRONT, POS_MAX, 32'hFFFF_FFFF);
      send_item(pae_pkg::OP_INS_POS,   9'd3,    32'h0000_0000);
      send_item(pae_pkg::OP_INS_POS,   9'd2,    32'h0000_0001);
      send_item(pae_pkg::OP_SEARCH,    '0,      32'h8000_0000);
      send_item(pae_pkg::OP_SEARCH,    '0,      32'h7FFF_FFFF);
      send_item(pae_pkg::OP_SEARCH,    '0,      32'h0000_3039);
      send_item(OP_UNUSED,             POS_MAX, 32'hFFFF_FFFF);
      send_item(pae_pkg::OP_DEL_POS,   9'd5,    32'h0000_0000);
      send_item(pae_pkg::OP_DEL_POS,   9'd256,  32'h0000_0000);
      send_item(pae_pkg::OP_INS_POS,   POS_MAX, 32'h5555_AAAA);
      send_item(pae_pkg::OP_DEL_POS,   9'd2,    32'h0000_0000);
      send_item(pae_pkg::OP_DEL_FRONT, '0,      32'h0000_0000);
      send_item(pae_pkg::OP_DEL_BACK,  '0,      32'h0000_0000);
      send_item(pae_pkg::OP_SEARCH,    '0,      32'hFFFF_FFFF);
      wait_drained();
   endtask

   task automatic test_fill_and_drain();
      set_idling(0, 0);
      while (shadow_count < DEPTH)
         send_item(choose_op(100, 0), choose_position(), choose_value());
      // probe the full array: position errors win over full
      send_item(pae_pkg::OP_INS_FRONT, '0,      choose_value());
      send_item(pae_pkg::OP_INS_BACK,  '0,      choose_value());
      send_item(pae_pkg::OP_INS_POS,   9'd256,  choose_value());
      send_item(pae_pkg::OP_INS_POS,   9'd257,  choose_value());
      send_item(pae_pkg::OP_INS_POS,   POS_MAX, choose_value());
      send_item(pae_pkg::OP_SEARCH,    '0,      choose_probe_value());
      send_item(pae_pkg::OP_SEARCH,    '0,      $urandom);
      send_item(pae_pkg::OP_DEL_POS,   9'd256,  '0);
      send_item(pae_pkg::OP_DEL_POS,   9'd255,  '0);
      send_item(pae_pkg::OP_INS_POS,   9'd255,  choose_value());
      set_idling(17, 17);
      while (shadow_count > 0)
         send_item(choose_op(0, 10), choose_position(), choose_probe_value());
      send_item(pae_pkg::OP_DEL_POS, POS_MAX, '0);
      send_item(pae_pkg::OP_SEARCH,  '0,      '0);
      wait_drained();
   endtask

   task automatic test_random_steady();
      set_idling(0, 0);
      run_random_items(110, 45, 15);
      wait_drained();
   endtask

   task automatic test_random_sender_gaps();
      set_idling(72, 0);
      run_random_items(110, 45, 15);
      wait_drained();
   endtask

   task automatic test_random_receiver_stalls();
      set_idling(0, 72);
      run_random_items(110, 45, 15);
      wait_drained();
   endtask

   task automatic test_random_both_idle();
      set_idling(17, 17);
      run_random_items(110, 45, 15);
      wait_drained();
   endtask

   task automatic test_receiver_hold();
      set_idling(0, 0);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      run_random_items(8, 60, 15);
      wait_drained();
      run_random_items(8, 45, 15);
      wait_drained();
   endtask

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      if (hold_kick) hold_left <= LONG_HOLD;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      rsp_stall <= hold_kick || hold_left > 1 || ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic void note_mismatch(string what, int want, int got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
   endfunction

   always @(posedge clock) begin
      array_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            note_mismatch("unexpected transfer, status", -1, rsp_status);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status) note_mismatch("status", want.status, rsp_status);
            if (rsp_found !== want.found) note_mismatch("found", want.found, rsp_found);
            if (rsp_entry_count !== want.entry_count)
               note_mismatch("entry_count", want.entry_count, rsp_entry_count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_and_drain();
      test_random_steady();
      test_random_sender_gaps();
      test_random_receiver_stalls();
      test_random_both_idle();
      test_receiver_hold();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
